// ===== hdl/acfb_pkg.sv =====
// Shared types, frame constants and command codes for the IR frame builder.
package acfb_pkg;

  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned VAR_LEN   = 6;   // bytes 6..11 depend on the command

  typedef logic [3:0] byte_idx_t;
  typedef logic [2:0] mode_t;
  typedef logic [VAR_LEN-1:0][7:0] var_bytes_t;

  localparam byte_idx_t LAST_IDX = byte_idx_t'(FRAME_LEN - 1);

  // Unreversed frame head: length code, then the fixed header.
  localparam logic [7:0] LEN_CODE = 8'h58;
  localparam logic [7:0] HDR1     = 8'h52;
  localparam logic [7:0] HDR2     = 8'hAE;
  localparam logic [7:0] HDR3     = 8'hC3;
  localparam logic [7:0] HDR4     = 8'h26;
  localparam logic [7:0] HDR5     = 8'hD9;

  localparam logic [7:0] FAN_MODE_B10 = 8'h27;
  localparam logic [7:0] FAN_MODE_B11 = 8'hD8;

  // Fan speed codes
  localparam logic [7:0] FAN_AUTO   = 8'd1;
  localparam logic [7:0] FAN_HIGH   = 8'd2;
  localparam logic [7:0] FAN_MEDIUM = 8'd3;
  localparam logic [7:0] FAN_LOW    = 8'd4;

  // Operating mode codes
  localparam logic [7:0] OPM_FAN  = 8'd1;
  localparam logic [7:0] OPM_COOL = 8'd2;
  localparam logic [7:0] OPM_HEAT = 8'd3;
  localparam logic [7:0] OPM_DRY  = 8'd4;
  localparam logic [7:0] OPM_OFF  = 8'd5;

  // Remembered mode
  localparam mode_t PM_NONE = 3'd0;
  localparam mode_t PM_FAN  = 3'd1;
  localparam mode_t PM_COOL = 3'd2;
  localparam mode_t PM_HEAT = 3'd3;
  localparam mode_t PM_DRY  = 3'd4;

  localparam logic [7:0] TEMP_MIN = 8'd18;
  localparam logic [7:0] TEMP_MAX = 8'd30;
  localparam logic [3:0] K_OUT_OF_RANGE = 4'd13;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/acfb_if.sv =====
// Valid/ready channel interfaces for commands and frame bytes.
interface acfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] temperature;
  logic [7:0] fan_speed;
  logic       horizontal_swing;
  logic       vertical_swing;
  logic [7:0] op_mode;

  modport source (output valid, temperature, fan_speed, horizontal_swing,
                  vertical_swing, op_mode, input ready);
  modport sink   (input valid, temperature, fan_speed, horizontal_swing,
                  vertical_swing, op_mode, output ready);
endinterface

interface acfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [3:0] byte_index;
  logic       last_byte;

  modport source (output valid, frame_byte, byte_index, last_byte, input ready);
  modport sink   (input valid, frame_byte, byte_index, last_byte, output ready);
endinterface

// ===== hdl/acfb_encoder.sv =====
// Builds the command-dependent frame bytes (6..11, bit-reversed) and the next remembered mode.
module acfb_encoder (
  input  logic [7:0]          temperature,
  input  logic [7:0]          fan_speed,
  input  logic                horizontal_swing,
  input  logic                vertical_swing,
  input  logic [7:0]          op_mode,
  input  acfb_pkg::mode_t     prev_mode,
  output acfb_pkg::var_bytes_t var_bytes,
  output acfb_pkg::mode_t     prev_mode_nxt
);
  import acfb_pkg::*;

  logic [7:0] b6, b7, b8, b9, b10, b11;
  logic [7:0] fan8, fan9;
  logic [3:0] k;
  logic [3:0] lo10, lo11;

  always_comb begin
    b6 = horizontal_swing ? 8'h7F : 8'hFF;
    b7 = horizontal_swing ? 8'h80 : 8'h00;

    unique case (fan_speed)
      FAN_AUTO:   begin fan8 = 8'hFF; fan9 = 8'h00; end
      FAN_HIGH:   begin fan8 = 8'h7F; fan9 = 8'h80; end
      FAN_MEDIUM: begin fan8 = 8'h9F; fan9 = 8'h60; end
      FAN_LOW:    begin fan8 = 8'hBF; fan9 = 8'h40; end
      default:    begin fan8 = 8'h0F; fan9 = 8'h00; end
    endcase
    // vertical swing moves the pair by 0x10, wrapping
    b8 = vertical_swing ? fan8 - 8'h10 : fan8;
    b9 = vertical_swing ? fan9 + 8'h10 : fan9;

    if (temperature >= TEMP_MIN && temperature <= TEMP_MAX) begin
      k = 4'(temperature - TEMP_MIN);
    end else begin
      k = K_OUT_OF_RANGE;
    end

    lo10 = 4'h0;
    lo11 = 4'h0;
    prev_mode_nxt = prev_mode;
    unique case (op_mode)
      OPM_FAN:  prev_mode_nxt = PM_FAN;
      OPM_COOL: begin lo10 = 4'h6; lo11 = 4'h9; prev_mode_nxt = PM_COOL; end
      OPM_HEAT: begin lo10 = 4'h3; lo11 = 4'hC; prev_mode_nxt = PM_HEAT; end
      OPM_DRY:  begin lo10 = 4'h5; lo11 = 4'hA; prev_mode_nxt = PM_DRY; end
      OPM_OFF: begin
        // off encodes the last real mode
        unique case (prev_mode)
          PM_FAN:  begin lo10 = 4'hF; lo11 = 4'h0; end
          PM_COOL: begin lo10 = 4'hE; lo11 = 4'h1; end
          PM_HEAT: begin lo10 = 4'hB; lo11 = 4'h4; end
          PM_DRY:  begin lo10 = 4'hD; lo11 = 4'h2; end
          default: begin lo10 = 4'h0; lo11 = 4'h0; end
        endcase
      end
      default: ;
    endcase

    if (op_mode == OPM_FAN) begin
      b10 = FAN_MODE_B10;
      b11 = FAN_MODE_B11;
    end else begin
      b10 = {4'hE - k, lo10};
      b11 = {4'h1 + k, lo11};
    end

    var_bytes[0] = rev8(b6);
    var_bytes[1] = rev8(b7);
    var_bytes[2] = rev8(b8);
    var_bytes[3] = rev8(b9);
    var_bytes[4] = rev8(b10);
    var_bytes[5] = rev8(b11);
  end

endmodule

// ===== hdl/ac_ir_command_frame_builder.sv =====
// Top level: accepts AC commands and streams 12-byte IR frames.
// Usage:
//   in_cmd    : command request (temperature, fan_speed, swing bits, op_mode),
//               taken when valid and ready are both high.
//   out_frame : one frame byte per request with byte_index and last_byte;
//               byte 0 is the length code, bytes 1..11 are bit-reversed.
// A command is encoded in the cycle it is accepted and parked in a pending
// frame register. When the byte streamer is free the pending frame moves
// into it and bytes go out at one per cycle while out_frame.ready is high.
// Path: an accepted command passes through the pending frame register and
// then the streamer register before its first byte is shown.
// Command rate is set by the byte streamer sending one byte per cycle while
// out_frame.ready is high; the pending register lets the next command be
// taken while the current frame is still going out.
// Stall: a low out_frame.ready holds the current byte; once the pending
// register is full, in_cmd.ready drops until the streamer frees it.
// Reset (rst_n low, synchronous): both frame registers empty, the remembered
// mode cleared to "no mode yet", so an off command then encodes zero nibbles.
module ac_ir_command_frame_builder (
  input  logic         clk,
  input  logic         rst_n,
  acfb_cmd_if.sink     in_cmd,
  acfb_frame_if.source out_frame
);
  import acfb_pkg::*;

  mode_t      prev_mode_r;
  mode_t      prev_mode_nxt;
  var_bytes_t enc_bytes;
  var_bytes_t pend_bytes_r;
  var_bytes_t act_bytes_r;
  logic       pend_valid_r;
  logic       act_valid_r;
  byte_idx_t  idx_r;

  logic in_fire, out_fire, act_done, act_load;

  acfb_encoder u_enc (
    .temperature      (in_cmd.temperature),
    .fan_speed        (in_cmd.fan_speed),
    .horizontal_swing (in_cmd.horizontal_swing),
    .vertical_swing   (in_cmd.vertical_swing),
    .op_mode          (in_cmd.op_mode),
    .prev_mode        (prev_mode_r),
    .var_bytes        (enc_bytes),
    .prev_mode_nxt    (prev_mode_nxt)
  );

  assign in_cmd.ready = !pend_valid_r;
  assign in_fire      = in_cmd.valid && !pend_valid_r;
  assign out_fire     = act_valid_r && out_frame.ready;
  assign act_done     = out_fire && (idx_r == LAST_IDX);
  assign act_load     = pend_valid_r && (!act_valid_r || act_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mode_r  <= PM_NONE;
      pend_valid_r <= 1'b0;
      act_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (in_fire) begin
        prev_mode_r  <= prev_mode_nxt;
        pend_valid_r <= 1'b1;
      end else if (act_load) begin
        pend_valid_r <= 1'b0;
      end

      if (act_load) begin
        act_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (act_done) begin
        act_valid_r <= 1'b0;
        idx_r       <= '0;
      end else if (out_fire) begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_bytes_r <= enc_bytes;
    end
    if (act_load) begin
      act_bytes_r <= pend_bytes_r;
    end
  end

  always_comb begin
    unique case (idx_r)
      4'd0:    out_frame.frame_byte = LEN_CODE;
      4'd1:    out_frame.frame_byte = rev8(HDR1);
      4'd2:    out_frame.frame_byte = rev8(HDR2);
      4'd3:    out_frame.frame_byte = rev8(HDR3);
      4'd4:    out_frame.frame_byte = rev8(HDR4);
      4'd5:    out_frame.frame_byte = rev8(HDR5);
      4'd6:    out_frame.frame_byte = act_bytes_r[0];
      4'd7:    out_frame.frame_byte = act_bytes_r[1];
      4'd8:    out_frame.frame_byte = act_bytes_r[2];
      4'd9:    out_frame.frame_byte = act_bytes_r[3];
      4'd10:   out_frame.frame_byte = act_bytes_r[4];
      4'd11:   out_frame.frame_byte = act_bytes_r[5];
      default: out_frame.frame_byte = 8'h00;
    endcase
  end

  assign out_frame.valid      = act_valid_r;
  assign out_frame.byte_index = idx_r;
  assign out_frame.last_byte  = (idx_r == LAST_IDX);

endmodule
